### hw/rtl/point_color_hash_map_macros.svh
// Assertion macros for the point color hash map.
// Included by the modules that carry concurrent assertions; uses their clock and reset.
`ifndef POINT_COLOR_HASH_MAP_MACROS_SVH
`define POINT_COLOR_HASH_MAP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCHM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCHM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/pchm_pkg.sv
// Shared types and constants of the point color hash map.
// No dependencies; used by point_color_hash_map.
package pchm_pkg;

   // Default geometry of the table.
   localparam int BUCKETS_DEFAULT = 1024;
   localparam int WAYS_DEFAULT    = 8;

   // Field widths of a transaction.
   localparam int COORD_W    = 31;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 8;

   // Operation codes carried on req_tuser.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // One stored point and its color.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               color;
   } entry_type;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      ST_CLEAR     = 7'b0000001,
      ST_IDLE      = 7'b0000010,
      ST_MOD       = 7'b0000100,
      ST_FILL_RD   = 7'b0001000,
      ST_FILL_WAIT = 7'b0010000,
      ST_SCAN      = 7'b0100000,
      ST_WRITE     = 7'b1000000
   } state_type;

endpackage

### hw/rtl/point_color_hash_map.sv
// Point color hash map: the sequencer, the bucket fill memory and the entry memory.
// Depends on pchm_pkg and point_color_hash_map_macros.svh.
//
// Maps a point (x, y) to a one-bit color. The bucket is x modulo BUCKETS and holds up to
// WAYS points. An insert (req_tuser low) updates a matching point or appends a new one and
// flags dropped when the bucket is full; a query (req_tuser high) reports found and color.
// One transaction is processed at a time and req_tready is low while it is in progress.
// A transaction passes through bucket select, fill read, slot scan and update. A match
// ends the scan at the compare that finds it; a miss compares every entry in the bucket
// first. The entry memory is read one slot per cycle through its single read port. A
// BUCKETS value that is not a power of two adds a step in which the bucket is formed
// from a quotient that a reciprocal multiplication produced at acceptance. After reset
// a clearing pass zeroes every fill count, and no transaction is accepted until it ends.
// A result waits in an output register until rsp_tready takes it; the next transaction
// is accepted meanwhile, but it cannot finish and return to idle while the previous
// result is still waiting.
module point_color_hash_map #(
   parameter int BUCKETS = pchm_pkg::BUCKETS_DEFAULT,
   parameter int WAYS    = pchm_pkg::WAYS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [30:0] coord_x, [61:31] coord_y, [62] color_in, [63] zero
   input  logic [pchm_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] opcode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] found, [1] color_out, [2] dropped, [7:3] zero
   output logic [pchm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

`include "point_color_hash_map_macros.svh"

   localparam int CW    = pchm_pkg::COORD_W;
   localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SLOTS = BUCKETS * WAYS;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FW    = $clog2(WAYS + 1);
   localparam bit POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);

   // Reciprocal of BUCKETS, exact for every CW-bit coordinate.
   localparam int          LOG2B     = $clog2(BUCKETS);
   localparam int          RECIP_SH  = CW + LOG2B;
   localparam logic [63:0] RECIP_NUM = 64'(1) << RECIP_SH;
   localparam logic [31:0] RECIP     =
      32'((RECIP_NUM + 64'(BUCKETS) - 64'(1)) / 64'(BUCKETS));

   // Sequencer and transaction registers.
   pchm_pkg::state_type state_ff, state_in;
   logic [BW-1:0]       clr_ff, clr_in;
   logic                op_ff, op_in;
   logic [CW-1:0]       x_ff, x_in;
   logic [CW-1:0]       y_ff, y_in;
   logic                col_ff, col_in;
   logic [CW-1:0]       quo_ff, quo_in;
   logic [BW-1:0]       bucket_ff, bucket_in;
   logic [SW-1:0]       base_ff, base_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [FW-1:0]       way_ff, way_in;
   logic                pend_ff, pend_in;
   logic [SW-1:0]       pend_addr_ff, pend_addr_in;
   logic                hit_ff, hit_in;
   logic                hit_color_ff, hit_color_in;
   logic [SW-1:0]       hit_addr_ff, hit_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_bits_ff, rsp_bits_in;

   // Memory ports.
   logic [FW-1:0]       fill_mem [BUCKETS];
   logic [FW-1:0]       fill_rd_ff;
   logic                fill_re, fill_we;
   logic [BW-1:0]       fill_wa;
   logic [FW-1:0]       fill_wd;
   pchm_pkg::entry_type ent_mem [SLOTS];
   pchm_pkg::entry_type ent_rd_ff;
   logic                ent_re, ent_we;
   logic [SW-1:0]       ent_wa;

   // Shared datapath pieces.
   logic [FW-1:0]       slot_idx;
   logic [SW-1:0]       slot_addr;
   logic [CW+31:0]      quo_prod;
   logic [CW:0]         rem_full;
   logic                cmp_hit;
   logic                out_free;

   // The update step addresses the append slot, the scan addresses the next way.
   assign slot_idx  = (state_ff == pchm_pkg::ST_WRITE) ? fill_ff : way_ff;
   assign slot_addr = base_ff + SW'(slot_idx);
   assign quo_prod  = (CW+32)'(req_tdata[CW-1:0]) * (CW+32)'(RECIP);
   assign rem_full  = {1'b0, x_ff} - (CW+1)'({1'b0, quo_ff} * (CW+1)'(BUCKETS));
   assign cmp_hit   = pend_ff && (ent_rd_ff.x == x_ff) && (ent_rd_ff.y == y_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == pchm_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(pchm_pkg::RSP_DATA_W - 3)'(0), rsp_bits_ff};

   // Sequencer: clear, bucket select, fill read, slot scan, update.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      col_in       = col_ff;
      quo_in       = quo_ff;
      bucket_in    = bucket_ff;
      base_in      = base_ff;
      fill_in      = fill_ff;
      way_in       = way_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      hit_in       = hit_ff;
      hit_color_in = hit_color_ff;
      hit_addr_in  = hit_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_bits_in  = rsp_bits_ff;
      fill_re      = 1'b0;
      fill_we      = 1'b0;
      fill_wa      = bucket_ff;
      fill_wd      = '0;
      ent_re       = 1'b0;
      ent_we       = 1'b0;
      ent_wa       = slot_addr;
      unique case (state_ff)
         pchm_pkg::ST_CLEAR: begin
            fill_we = 1'b1;
            fill_wa = clr_ff;
            if (clr_ff == BW'(BUCKETS - 1)) begin
               state_in = pchm_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         pchm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               x_in      = req_tdata[CW-1:0];
               y_in      = req_tdata[2*CW-1:CW];
               col_in    = req_tdata[2*CW];
               way_in    = '0;
               pend_in   = 1'b0;
               hit_in    = 1'b0;
               quo_in    = CW'(quo_prod >> RECIP_SH);
               bucket_in = BW'(req_tdata[CW-1:0]) & BW'(BUCKETS - 1);
               state_in  = POW2 ? pchm_pkg::ST_FILL_RD : pchm_pkg::ST_MOD;
            end
         end
         pchm_pkg::ST_MOD: begin
            // The remainder is the coordinate minus the quotient times BUCKETS.
            bucket_in = rem_full[BW-1:0];
            state_in  = pchm_pkg::ST_FILL_RD;
         end
         pchm_pkg::ST_FILL_RD: begin
            fill_re  = 1'b1;
            base_in  = SW'(bucket_ff * WAYS);
            state_in = pchm_pkg::ST_FILL_WAIT;
         end
         pchm_pkg::ST_FILL_WAIT: begin
            fill_in  = fill_rd_ff;
            state_in = pchm_pkg::ST_SCAN;
         end
         pchm_pkg::ST_SCAN: begin
            // Read one slot per cycle and compare the slot read in the previous cycle.
            ent_re       = (way_ff < fill_ff);
            pend_in      = ent_re;
            pend_addr_in = slot_addr;
            if (ent_re) begin
               way_in = way_ff + 1'b1;
            end
            if (cmp_hit) begin
               hit_in       = 1'b1;
               hit_color_in = ent_rd_ff.color;
               hit_addr_in  = pend_addr_ff;
               state_in     = pchm_pkg::ST_WRITE;
            end else if (!ent_re && !pend_ff) begin
               state_in = pchm_pkg::ST_WRITE;
            end
         end
         pchm_pkg::ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bits_in  = {1'b0, hit_ff && hit_color_ff, hit_ff};
               if (op_ff == pchm_pkg::OP_INSERT) begin
                  if (hit_ff) begin
                     ent_we = 1'b1;
                     ent_wa = hit_addr_ff;
                  end else if (fill_ff < FW'(WAYS)) begin
                     ent_we  = 1'b1;
                     fill_we = 1'b1;
                     fill_wd = fill_ff + 1'b1;
                  end else begin
                     rsp_bits_in[2] = 1'b1;
                  end
               end
               state_in = pchm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pchm_pkg::ST_CLEAR;
         end
      endcase
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pchm_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      col_ff       <= col_in;
      quo_ff       <= quo_in;
      bucket_ff    <= bucket_in;
      base_ff      <= base_in;
      fill_ff      <= fill_in;
      way_ff       <= way_in;
      pend_ff      <= pend_in;
      pend_addr_ff <= pend_addr_in;
      hit_ff       <= hit_in;
      hit_color_ff <= hit_color_in;
      hit_addr_ff  <= hit_addr_in;
      rsp_bits_ff  <= rsp_bits_in;
   end

   // Bucket fill count memory.
   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_wa] <= fill_wd;
      end
      if (fill_re) begin
         fill_rd_ff <= fill_mem[bucket_ff];
      end
   end

   // Entry memory, one row of WAYS slots per bucket.
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_wa] <= {x_ff, y_ff, col_ff};
      end
      if (ent_re) begin
         ent_rd_ff <= ent_mem[slot_addr];
      end
   end

   // Checks on the sequencer and the result.
   `PCHM_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready,
      "a second transaction was accepted while one is in progress")
   `PCHM_ASSERT_NOW(a_fill_bound, fill_we && (state_ff != pchm_pkg::ST_CLEAR),
      fill_wd <= FW'(WAYS), "bucket fill count written beyond the number of ways")
   `PCHM_ASSERT_NOW(a_scan_bound, state_ff == pchm_pkg::ST_SCAN, way_ff <= fill_ff,
      "slot scan ran past the bucket fill count")
   `PCHM_ASSERT_NOW(a_drop_excl, rsp_valid_ff, !(rsp_bits_ff[0] && rsp_bits_ff[2]),
      "result reports both found and dropped")
   `PCHM_ASSERT_NEXT(a_result_load, (state_ff == pchm_pkg::ST_WRITE) && out_free,
      rsp_valid_ff, "finished transaction did not load the result register")

endmodule
